>>> src/vertical_box_filter_9tap_assert.svh
// Assertion macros for the filter RTL.
`ifndef VERTICAL_BOX_FILTER_9TAP_ASSERT_SVH
`define VERTICAL_BOX_FILTER_9TAP_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define VBF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition on one edge implies a property on the next edge.
`define VBF_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);
`else
`define VBF_ASSERT(lbl, prop, msg)
`define VBF_ASSERT_NEXT(lbl, cond, prop, msg)
`endif
`endif

>>> src/vbf_pkg.sv
package vbf_pkg;

  localparam int PIX_W     = 16;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_ROWS = 1'b1;

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  typedef logic signed [PIX_W-1:0] pix_t;

  // Control that travels with each beat down the cell chain
  typedef struct packed {
    logic valid;
    logic produce;
    logic eol;
    logic eof;
  } beat_ctrl_t;

endpackage

>>> src/vertical_box_filter_9tap.sv
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_stall_o   pixel_in_i
// out       output     out_valid_o / out_stall_i pixel_out_o, end_of_line_o, end_of_frame_o
// cfg       input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// One input beat per cycle while the output is not stalled; a result beat passes every cell, then the scale stages.
// The rate is set by the row slot RAMs, one per cell, each read whenever the chain moves and written only for its slot.
// A stalled output beat freezes the whole cell chain and raises in_stall_o.
// Reset clears counters, control flags and configuration registers; line RAMs are not cleared.
// Border rows are stored only and give no result beat.
`include "vertical_box_filter_9tap_assert.svh"

module vertical_box_filter_9tap #(
  parameter int HALF_TAPS = 4,
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_ROWS  = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  vbf_pkg::pix_t                       pixel_in_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output vbf_pkg::pix_t                       pixel_out_o,
  output logic                                end_of_line_o,
  output logic                                end_of_frame_o,
  input  logic                                cfg_we_i,
  input  logic [vbf_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [vbf_pkg::CFG_W-1:0]           cfg_data_i
);

  import vbf_pkg::*;

  localparam int STORED = 2 * HALF_TAPS;
  localparam int TAPS   = STORED + 1;
  localparam int MEAN   = (65536 + TAPS / 2) / TAPS;
  localparam int SUM_W  = PIX_W + $clog2(TAPS);
  localparam int SLOT_W = $clog2(STORED);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_ROWS + STORED);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int WC_W   = (WW > CFG_W) ? WW : CFG_W;
  localparam int FW     = $clog2(MAX_ROWS + STORED + 1);
  localparam int FR_W   = (FW > CFG_W) ? FW : CFG_W;
  localparam logic [FR_W-1:0] RECIP = FR_W'((2 ** FR_W) / STORED);

  logic              en, accept;
  logic [CFG_W-1:0]  width_q, rows_q;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [SLOT_W-1:0] slot_q, slot_d;

  logic [WC_W-1:0]   width_ext, width_eff, col_ext, col_last, col_sel;
  logic [FR_W-1:0]   rows_ext, rows_eff, frame_last, row_ext, row_sel;
  logic              last_col, last_row, row_clamp, produce;
  logic [2*FR_W-1:0] mod_prod;
  logic [FR_W-1:0]   mod_quo, mod_sub, mod_rem, mod_fix;
  logic [SLOT_W-1:0] slot_sel;

  // Chain taps, one entry per cell boundary
  beat_ctrl_t              ctrl_s [STORED+1];
  logic [COL_W-1:0]        col_s  [STORED+1];
  logic [SLOT_W-1:0]       slot_s [STORED+1];
  pix_t                    pix_s  [STORED+1];
  logic signed [SUM_W-1:0] psum_s [STORED+1];

  // Move the chain unless a result beat waits on a stalled output
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;
  assign accept     = in_valid_i && en;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= CFG_RESET;
      rows_q  <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LINE_WIDTH:  width_q <= cfg_data_i;
        REG_OUTPUT_ROWS: rows_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Limit width and row count to the supported range
  always_comb begin
    width_ext = WC_W'(width_q);
    if (width_ext == '0) begin
      width_eff = WC_W'(1);
    end else if (width_ext > WC_W'(MAX_WIDTH)) begin
      width_eff = WC_W'(MAX_WIDTH);
    end else begin
      width_eff = width_ext;
    end
    rows_ext = FR_W'(rows_q);
    if (rows_ext == '0) begin
      rows_eff = FR_W'(1);
    end else if (rows_ext > FR_W'(MAX_ROWS)) begin
      rows_eff = FR_W'(MAX_ROWS);
    end else begin
      rows_eff = rows_ext;
    end
  end

  // Pull counters back inside the frame after a shrinking register write
  always_comb begin
    col_ext    = WC_W'(col_q);
    col_last   = width_eff - WC_W'(1);
    col_sel    = (col_ext >= width_eff) ? col_last : col_ext;
    last_col   = (col_sel == col_last);
    frame_last = rows_eff + FR_W'(STORED - 1);
    row_ext    = FR_W'(row_q);
    row_clamp  = (row_ext > frame_last);
    row_sel    = row_clamp ? frame_last : row_ext;
    last_row   = (row_sel == frame_last);
    produce    = (row_sel >= FR_W'(STORED));
  end

  // Slot of the last frame row: reciprocal multiply and one correction
  always_comb begin
    mod_prod = {{FR_W{1'b0}}, frame_last} * {{FR_W{1'b0}}, RECIP};
    mod_quo  = mod_prod[2*FR_W-1:FR_W];
    mod_sub  = mod_quo * FR_W'(STORED);
    mod_rem  = frame_last - mod_sub;
    mod_fix  = (mod_rem >= FR_W'(STORED)) ? mod_rem - FR_W'(STORED) : mod_rem;
    slot_sel = row_clamp ? SLOT_W'(mod_fix) : slot_q;
  end

  // Step column, row and row slot
  always_comb begin
    if (last_col) begin
      col_d = '0;
      if (last_row) begin
        row_d  = '0;
        slot_d = '0;
      end else begin
        row_d  = ROW_W'(row_sel + FR_W'(1));
        slot_d = (slot_sel == SLOT_W'(STORED - 1)) ? '0 : slot_sel + SLOT_W'(1);
      end
    end else begin
      col_d  = COL_W'(col_sel + WC_W'(1));
      row_d  = ROW_W'(row_sel);
      slot_d = slot_sel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      slot_q <= '0;
    end else if (accept) begin
      col_q  <= col_d;
      row_q  <= row_d;
      slot_q <= slot_d;
    end
  end

  // Feed the accepted beat into the first cell
  assign ctrl_s[0] = '{valid: accept, produce: produce, eol: last_col,
                       eof: last_col && last_row};
  assign col_s[0]  = COL_W'(col_sel);
  assign slot_s[0] = slot_sel;
  assign pix_s[0]  = pixel_in_i;
  assign psum_s[0] = SUM_W'(pixel_in_i);

  for (genvar k = 0; k < STORED; k++) begin : g_cell
    vbf_cell #(
      .IDX   (k),
      .DEPTH (MAX_WIDTH),
      .SLOT_W(SLOT_W),
      .SUM_W (SUM_W)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .ctrl_i(ctrl_s[k]),
      .col_i (col_s[k]),
      .slot_i(slot_s[k]),
      .pix_i (pix_s[k]),
      .psum_i(psum_s[k]),
      .ctrl_o(ctrl_s[k+1]),
      .col_o (col_s[k+1]),
      .slot_o(slot_s[k+1]),
      .pix_o (pix_s[k+1]),
      .psum_o(psum_s[k+1])
    );
  end

  vbf_scale #(
    .SUM_W(SUM_W),
    .MEAN (MEAN)
  ) u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctrl_i (ctrl_s[STORED]),
    .sum_i  (psum_s[STORED]),
    .valid_o(out_valid_o),
    .pixel_o(pixel_out_o),
    .eol_o  (end_of_line_o),
    .eof_o  (end_of_frame_o)
  );

  `VBF_ASSERT(a_slot_range, slot_q <= SLOT_W'(STORED - 1), "row slot out of range")
  `VBF_ASSERT(a_eof_eol, (out_valid_o && end_of_frame_o) |-> end_of_line_o, "frame end off line end")
  `VBF_ASSERT_NEXT(a_cnt_hold, !accept, $stable(col_q) && $stable(row_q), "counters moved idle")
  `VBF_ASSERT_NEXT(a_col_wrap, accept && last_col, col_q == '0, "column did not wrap")

endmodule

>>> src/vbf_ram.sv
module vbf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read; a read at the written address returns old data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/vbf_cell.sv
module vbf_cell #(
  parameter int IDX    = 0,
  parameter int DEPTH  = 1024,
  parameter int SLOT_W = 3,
  parameter int SUM_W  = 20
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  vbf_pkg::beat_ctrl_t      ctrl_i,
  input  logic [$clog2(DEPTH)-1:0] col_i,
  input  logic [SLOT_W-1:0]        slot_i,
  input  vbf_pkg::pix_t            pix_i,
  input  logic signed [SUM_W-1:0]  psum_i,
  output vbf_pkg::beat_ctrl_t      ctrl_o,
  output logic [$clog2(DEPTH)-1:0] col_o,
  output logic [SLOT_W-1:0]        slot_o,
  output vbf_pkg::pix_t            pix_o,
  output logic signed [SUM_W-1:0]  psum_o
);

  import vbf_pkg::*;

  localparam int AW = $clog2(DEPTH);

  beat_ctrl_t              ctrl_q;
  logic [AW-1:0]           col_q;
  logic [SLOT_W-1:0]       slot_q;
  pix_t                    pix_q;
  logic signed [SUM_W-1:0] psum_q;
  logic [PIX_W-1:0]        rdata;
  logic                    we;

  // Store the sample in this row slot when the beat belongs to it
  assign we = en_i && ctrl_i.valid && (slot_i == SLOT_W'(IDX));

  vbf_ram #(
    .WIDTH(PIX_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(col_i),
    .wdata_i(pix_i),
    .re_i   (en_i),
    .raddr_i(col_i),
    .rdata_o(rdata)
  );

  // Advance control with the chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  // Advance payload alongside the read
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      col_q  <= col_i;
      slot_q <= slot_i;
      pix_q  <= pix_i;
      psum_q <= psum_i;
    end
  end

  // Add this row's stored sample to the running column sum
  assign psum_o = psum_q + SUM_W'(signed'(rdata));
  assign ctrl_o = ctrl_q;
  assign col_o  = col_q;
  assign slot_o = slot_q;
  assign pix_o  = pix_q;

endmodule

>>> src/vbf_scale.sv
module vbf_scale #(
  parameter int SUM_W = 20,
  parameter int MEAN  = 7282
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  vbf_pkg::beat_ctrl_t     ctrl_i,
  input  logic signed [SUM_W-1:0] sum_i,
  output logic                    valid_o,
  output vbf_pkg::pix_t           pixel_o,
  output logic                    eol_o,
  output logic                    eof_o
);

  import vbf_pkg::*;

  localparam int PROD_W = SUM_W + 17;
  localparam logic signed [PROD_W-1:0] MEAN_EXT = PROD_W'(MEAN);
  localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(32768);
  localparam logic signed [PROD_W-1:0] MAX_V    = PROD_W'(32767);
  localparam logic signed [PROD_W-1:0] MIN_V    = PROD_W'(-32768);

  logic                     a_vld_q, b_vld_q, out_vld_q;
  logic                     a_eol_q, b_eol_q, out_eol_q;
  logic                     a_eof_q, b_eof_q, out_eof_q;
  logic signed [SUM_W-1:0]  a_sum_q;
  logic signed [PROD_W-1:0] b_prod_q;
  logic signed [PROD_W-1:0] sum_ext;
  logic signed [PROD_W-1:0] rnd;
  logic signed [PROD_W-1:0] quo;
  pix_t                     pix_d, pix_q;

  assign sum_ext = PROD_W'(a_sum_q);

  // Round to nearest, ties up, then clamp to the sample range
  always_comb begin
    rnd = b_prod_q + HALF_LSB;
    quo = rnd >>> 16;
    if (quo > MAX_V) begin
      pix_d = PIX_W'(MAX_V);
    end else if (quo < MIN_V) begin
      pix_d = PIX_W'(MIN_V);
    end else begin
      pix_d = PIX_W'(quo);
    end
  end

  // Hold valid flags of the three stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q   <= ctrl_i.valid && ctrl_i.produce;
      b_vld_q   <= a_vld_q;
      out_vld_q <= b_vld_q;
    end
  end

  // Capture sum, scale by one ninth, then register the result beat
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_sum_q   <= sum_i;
      a_eol_q   <= ctrl_i.eol;
      a_eof_q   <= ctrl_i.eof;
      b_prod_q  <= sum_ext * MEAN_EXT;
      b_eol_q   <= a_eol_q;
      b_eof_q   <= a_eof_q;
      pix_q     <= pix_d;
      out_eol_q <= b_eol_q;
      out_eof_q <= b_eof_q;
    end
  end

  assign valid_o = out_vld_q;
  assign pixel_o = pix_q;
  assign eol_o   = out_eol_q;
  assign eof_o   = out_eof_q;

endmodule

>>> bench/vertical_box_filter_9tap_checker.sv
`timescale 1ns / 100ps

module vertical_box_filter_9tap_checker #(
  parameter int HALF_TAPS = 4,
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_ROWS  = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  vbf_pkg::pix_t                 pixel_in_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  vbf_pkg::pix_t                 pixel_out_i,
  input  logic                          end_of_line_i,
  input  logic                          end_of_frame_i,
  input  logic                          cfg_we_i,
  input  logic [vbf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [vbf_pkg::CFG_W-1:0]     cfg_data_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  import vbf_pkg::*;

  localparam int STORED_ROWS     = 2 * HALF_TAPS;
  localparam int TAPS            = STORED_ROWS + 1;
  localparam int MEAN_WEIGHT_Q16 = (65536 + TAPS / 2) / TAPS;
  localparam int MAX_REPORTS     = 10;

  typedef struct packed {
    pix_t pixel;
    logic eol;
    logic eof;
  } mean_beat_t;

  mean_beat_t       pending_means[$];
  pix_t             line_mem [STORED_ROWS][MAX_WIDTH];
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] rows_reg;
  int unsigned      col_cnt;
  int unsigned      row_cnt;
  int               mismatches = 0;

  // Map a register value onto the range the block honors
  function automatic int unsigned span(logic [CFG_W-1:0] v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Take one input beat: queue the column mean it yields and update the line store
  task automatic absorb_pixel(pix_t px);
    int unsigned w;
    int unsigned frame_rows;
    int unsigned c;
    int unsigned r;
    int          k;
    logic        last_col;
    logic        last_row;
    longint      acc;
    mean_beat_t  beat;
    w          = span(width_reg, MAX_WIDTH);
    frame_rows = span(rows_reg, MAX_ROWS) + STORED_ROWS;
    c          = (col_cnt >= w) ? w - 1 : col_cnt;
    r          = (row_cnt >= frame_rows) ? frame_rows - 1 : row_cnt;
    last_col   = (c == w - 1);
    last_row   = (r == frame_rows - 1);
    if (r >= STORED_ROWS) begin
      acc = px;
      for (k = 0; k < STORED_ROWS; k++) begin
        acc += line_mem[k][c];
      end
      // scale by one ninth in Q16, round half up, saturate
      acc = (acc * MEAN_WEIGHT_Q16 + 32768) >>> 16;
      if (acc > 32767) begin
        acc = 32767;
      end else if (acc < -32768) begin
        acc = -32768;
      end
      beat.pixel = pix_t'(acc);
      beat.eol   = last_col;
      beat.eof   = last_col && last_row;
      pending_means.push_back(beat);
    end
    // overwrite the oldest row at this column
    line_mem[r % STORED_ROWS][c] = px;
    if (last_col) begin
      col_cnt = 0;
      row_cnt = last_row ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
      row_cnt = r;
    end
  endtask

  // Track register writes, score output beats, then predict from input beats
  always @(posedge clk_i or negedge rst_ni) begin
    mean_beat_t want;
    if (!rst_ni) begin
      pending_means.delete();
      col_cnt      = 0;
      row_cnt      = 0;
      width_reg    = CFG_RESET;
      rows_reg     = CFG_RESET;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_LINE_WIDTH: begin
            width_reg = cfg_data_i;
          end
          REG_OUTPUT_ROWS: begin
            rows_reg = cfg_data_i;
          end
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (pending_means.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: output beat with nothing expected: pixel=%0d eol=%b eof=%b",
                     $realtime, pixel_out_i, end_of_line_i, end_of_frame_i);
          end
        end else begin
          want = pending_means.pop_front();
          if (want.pixel !== pixel_out_i || want.eol !== end_of_line_i ||
              want.eof !== end_of_frame_i) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("%0t: output beat mismatch: expected pixel=%0d eol=%b eof=%b,",
                       $realtime, want.pixel, want.eol, want.eof,
                       " got pixel=%0d eol=%b eof=%b",
                       pixel_out_i, end_of_line_i, end_of_frame_i);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        absorb_pixel(pixel_in_i);
      end
      pending_o    <= pending_means.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

>>> bench/vertical_box_filter_9tap_tb.sv
`timescale 1ns / 100ps

module vertical_box_filter_9tap_tb;
  import vbf_pkg::*;

  localparam int HALF_TAPS      = 4;
  localparam int MAX_WIDTH      = 1024;
  localparam int MAX_ROWS       = 1024;
  localparam int LATENCY        = 2 * HALF_TAPS + 3;
  localparam int SETTLE_CYCLES  = LATENCY + 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 960;
  localparam int CALM_ITEMS     = 150;

  localparam pix_t PIX_MAX = 16'sh7fff;
  localparam pix_t PIX_MIN = 16'sh8000;

  typedef enum int {MIX_WIDE, MIX_HIGH, MIX_LOW} pixel_mix_e;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  pix_t             pixel_in  = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  pix_t             pixel_out;
  logic             end_of_line;
  logic             end_of_frame;
  logic             cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = REG_LINE_WIDTH;
  logic [CFG_W-1:0] cfg_data  = '0;

  int         fail_count;
  int         pending;
  int         items_sent   = 0;
  int         in_free_left = 0;
  int         stall_left   = 0;
  int         free_left    = 0;
  int         quiet_cycles = 0;
  int         calm_from    = 2147483647;
  logic       calm         = 1'b0;
  pixel_mix_e pix_mix      = MIX_WIDE;

  vertical_box_filter_9tap #(
    .HALF_TAPS(HALF_TAPS),
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_ROWS (MAX_ROWS)
  ) i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .pixel_in_i    (pixel_in),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .pixel_out_o   (pixel_out),
    .end_of_line_o (end_of_line),
    .end_of_frame_o(end_of_frame),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data)
  );

  vertical_box_filter_9tap_checker #(
    .HALF_TAPS(HALF_TAPS),
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_ROWS (MAX_ROWS)
  ) i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .pixel_in_i    (pixel_in),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .pixel_out_i   (pixel_out),
    .end_of_line_i (end_of_line),
    .end_of_frame_i(end_of_frame),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always #4 clk = ~clk;

  // Stall the output in bursts separated by free stretches; hold off near the end
  always @(posedge clk) begin
    if (calm) begin
      out_stall <= 1'b0;
    end else if (free_left > 0) begin
      out_stall <= 1'b0;
      free_left <= free_left - 1;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= 1'b0;
      free_left  <= $urandom_range(0, 40);
      stall_left <= $urandom_range(1, 17);
    end
  end

  // End the run when no beat moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles < WATCHDOG_LIMIT) begin
      quiet_cycles <= quiet_cycles + 1;
    end else begin
      $display("vertical_box_filter_9tap test failed");
      $finish;
    end
  end

  function automatic int unsigned span(logic [CFG_W-1:0] v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic pix_t pick_pixel();
    case (pix_mix)
      MIX_HIGH: begin
        return ($urandom_range(0, 7) == 0) ? pix_t'($urandom) : PIX_MAX;
      end
      MIX_LOW: begin
        return ($urandom_range(0, 7) == 0) ? pix_t'($urandom) : PIX_MIN;
      end
      default: begin
        case ($urandom_range(0, 9))
          0: return PIX_MAX;
          1: return PIX_MIN;
          2, 3: return pix_t'(int'($urandom_range(0, 64)) - 32);
          default: return pix_t'($urandom);
        endcase
      end
    endcase
  endfunction

  // Drop valid, wait for every expected beat, then let the pipeline drain
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(logic [CFG_W-1:0] w, logic [CFG_W-1:0] r);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_LINE_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    cfg_idx  <= REG_OUTPUT_ROWS;
    cfg_data <= r;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Offer one beat, maybe after an idle burst, and hold it until accepted
  task automatic send_pixel(pix_t value);
    int gap;
    if (items_sent >= calm_from) begin
      calm <= 1'b1;
    end
    if (!calm) begin
      if (in_free_left > 0) begin
        in_free_left--;
      end else begin
        gap          = $urandom_range(1, 17);
        in_free_left = $urandom_range(0, 40);
        in_valid     <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    pixel_in <= value;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic run_frames(logic [CFG_W-1:0] w, logic [CFG_W-1:0] r, int frames);
    int n;
    settle();
    configure(w, r);
    n = span(w, MAX_WIDTH) * (span(r, MAX_ROWS) + 2 * HALF_TAPS) * frames;
    repeat (n) send_pixel(pick_pixel());
  endtask

  // Start a frame, change the registers partway through, then finish the frame.
  // The new width must not exceed the old one so that no unwritten column is read.
  task automatic split_frame(logic [CFG_W-1:0] w1, logic [CFG_W-1:0] r1, int unsigned head,
                             logic [CFG_W-1:0] w2, logic [CFG_W-1:0] r2);
    int unsigned w1e;
    int unsigned w2e;
    int unsigned fr2;
    int unsigned c;
    int unsigned r;
    int unsigned rest;
    settle();
    configure(w1, r1);
    repeat (head) send_pixel(pick_pixel());
    w1e = span(w1, MAX_WIDTH);
    c   = head % w1e;
    r   = head / w1e;
    settle();
    configure(w2, r2);
    w2e = span(w2, MAX_WIDTH);
    fr2 = span(r2, MAX_ROWS) + 2 * HALF_TAPS;
    // counters past the new limits are clamped to the last column and row for the next beat
    if (c > w2e - 1) c = w2e - 1;
    if (r > fr2 - 1) r = fr2 - 1;
    rest = (w2e - c) + (fr2 - 1 - r) * w2e;
    repeat (rest) send_pixel(pick_pixel());
  endtask

  initial begin
    int               target;
    int unsigned      len;
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] r;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Saturate the mean at both ends; zero registers act as one
    settle();
    configure(11'd1, 11'd2);
    repeat (9) send_pixel(PIX_MAX);
    send_pixel(PIX_MIN);
    settle();
    configure(11'd0, 11'd0);
    repeat (9) send_pixel(PIX_MIN);

    // Register extremes: over-range width cut short mid-row, row clamp mid-frame
    pix_mix = MIX_WIDE;
    split_frame(11'd2047, 11'd1, 5, 11'd3, 11'd1);
    split_frame(11'd2, 11'd2047, 30, 11'd2, 11'd2);

    // Random frames of small sizes, some with registers changed mid-frame
    target    = items_sent + RANDOM_ITEMS;
    calm_from = target - CALM_ITEMS;
    while (items_sent < target) begin
      case ($urandom_range(0, 5))
        4: pix_mix = MIX_HIGH;
        5: pix_mix = MIX_LOW;
        default: pix_mix = MIX_WIDE;
      endcase
      case ($urandom_range(0, 9))
        0: w = '0;
        1: w = CFG_W'($urandom_range(9, 40));
        default: w = CFG_W'($urandom_range(1, 8));
      endcase
      r = CFG_W'($urandom_range(0, 5));
      if ($urandom_range(0, 2) == 0) begin
        len = span(w, MAX_WIDTH) * (span(r, MAX_ROWS) + 2 * HALF_TAPS);
        split_frame(w, r, $urandom_range(1, len - 1),
                    CFG_W'($urandom_range(0, span(w, MAX_WIDTH))),
                    CFG_W'($urandom_range(0, 12)));
      end else begin
        run_frames(w, r, $urandom_range(1, 2));
      end
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("vertical_box_filter_9tap test passed");
    end else begin
      $display("vertical_box_filter_9tap test failed");
    end
    $finish;
  end

endmodule
